/* hw/rtl/tts_pkg.sv */
// Shared types and constants for the timed trim and thrust sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

   // Operation codes carried in the input item's tuser.
   localparam logic OP_START  = 1'b0;
   localparam logic OP_ADJUST = 1'b1;

   // Phase codes reported with each result item.
   localparam logic [1:0] PHASE_TRIM     = 2'd0;
   localparam logic [1:0] PHASE_FORWARD  = 2'd1;
   localparam logic [1:0] PHASE_REVERSE  = 2'd2;
   localparam logic [1:0] PHASE_COMPLETE = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_DEPTH_SP    = 3'd0;
   localparam logic [2:0] REG_PITCH_SP    = 3'd1;
   localparam logic [2:0] REG_HEADING_SP  = 3'd2;
   localparam logic [2:0] REG_THROTTLE    = 3'd3;
   localparam logic [2:0] REG_SERVO_ZERO  = 3'd4;
   localparam logic [2:0] REG_TRIM_END    = 3'd5;
   localparam logic [2:0] REG_FORWARD_END = 3'd6;
   localparam logic [2:0] REG_REVERSE_END = 3'd7;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Heading wrap limits.
   localparam logic [15:0] HEADING_HALF_TURN = 16'd18000;
   localparam logic signed [16:0] HEADING_FULL_TURN = 17'sd36000;

   typedef struct packed {
      logic [15:0]        depth_sp;
      logic signed [14:0] pitch_sp;
      logic signed [15:0] heading_sp;
      logic [31:0]        throttle_pair;
      logic [23:0]        servo_zero;
      logic [31:0]        trim_end;
      logic [31:0]        forward_end;
      logic [31:0]        reverse_end;
   } tts_cfg_type;

   typedef struct packed {
      logic signed [5:0] rudder;
      logic signed [6:0] aft;
      logic signed [6:0] fore;
   } tts_corr_type;

endpackage

`default_nettype wire

/* hw/rtl/tts_csr.sv */
// Configuration registers of the sequencer, written through a plain write port.
// Depends on tts_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module tts_csr
   import tts_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]    csr_wr_data,
   output tts_cfg_type                 cfg
);

   tts_cfg_type cfg_ff;
   tts_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_DEPTH_SP:    cfg_in.depth_sp      = csr_wr_data[15:0];
            REG_PITCH_SP:    cfg_in.pitch_sp      = $signed(csr_wr_data[14:0]);
            REG_HEADING_SP:  cfg_in.heading_sp    = $signed(csr_wr_data[15:0]);
            REG_THROTTLE:    cfg_in.throttle_pair = csr_wr_data;
            REG_SERVO_ZERO:  cfg_in.servo_zero    = csr_wr_data[23:0];
            REG_TRIM_END:    cfg_in.trim_end      = csr_wr_data;
            REG_FORWARD_END: cfg_in.forward_end   = csr_wr_data;
            REG_REVERSE_END: cfg_in.reverse_end   = csr_wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/tts_trim.sv */
// Trim corrections: rounded, clamped proportional terms for rudder, aft and fore planes.
// Depends on tts_pkg for the configuration and correction structs.
`timescale 1ns / 1ps
`default_nettype none

module tts_trim
   import tts_pkg::*;
(
   input  tts_cfg_type        cfg,
   input  wire [15:0]         heading_cdeg,
   input  wire signed [14:0]  pitch_cdeg,
   input  wire [15:0]         depth_mm,
   output tts_corr_type       corr
);

   // Rudder: error over 20, rounded half away from zero, negated, clamped to 30.
   logic signed [16:0] dir;
   logic signed [17:0] h_err;
   logic signed [17:0] h_neg;
   logic [16:0]        h_abs;
   logic [9:0]         h_x;
   logic [15:0]        h_prod;
   logic [5:0]         h_q;

   // Aft plane: error over 50, clamped to 40.
   logic signed [16:0] p_err;
   logic signed [16:0] p_neg;
   logic [15:0]        p_abs;
   logic [11:0]        p_x;
   logic [20:0]        p_prod;
   logic [5:0]         p_q;

   // Fore plane: error over 5, negated, clamped to 40.
   logic signed [16:0] d_err;
   logic signed [16:0] d_neg;
   logic [15:0]        d_abs;
   logic [7:0]         d_x;
   logic [15:0]        d_prod;
   logic [5:0]         d_q;

   always_comb begin
      if (heading_cdeg > HEADING_HALF_TURN) begin
         dir = $signed({1'b0, heading_cdeg}) - HEADING_FULL_TURN;
      end else begin
         dir = $signed({1'b0, heading_cdeg});
      end
      h_err = {{2{cfg.heading_sp[15]}}, cfg.heading_sp} - {dir[16], dir};
      h_neg = -h_err;
      h_abs = h_err[17] ? h_neg[16:0] : h_err[16:0];
      // Below the clamp point (a+10)/20 equals ((a+10)>>2)/5, and x*205>>10 is exact here.
      h_x    = h_abs[9:0] + 10'd10;
      h_prod = {8'd0, h_x[9:2]} * 16'd205;
      h_q    = (h_abs >= 17'd610) ? 6'd30 : h_prod[15:10];
      corr.rudder = h_err[17] ? $signed(h_q) : -$signed(h_q);

      p_err = {{2{cfg.pitch_sp[14]}}, cfg.pitch_sp} - {{2{pitch_cdeg[14]}}, pitch_cdeg};
      p_neg = -p_err;
      p_abs = p_err[16] ? p_neg[15:0] : p_err[15:0];
      p_x    = {1'b0, p_abs[10:0]} + 12'd25;
      p_prod = {10'd0, p_x[11:1]} * 21'd1311;
      p_q    = (p_abs >= 16'd2025) ? 6'd40 : p_prod[20:15];
      corr.aft = p_err[16] ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});

      d_err = $signed({1'b0, cfg.depth_sp}) - $signed({1'b0, depth_mm});
      d_neg = -d_err;
      d_abs = d_err[16] ? d_neg[15:0] : d_err[15:0];
      d_x    = d_abs[7:0] + 8'd2;
      d_prod = {8'd0, d_x} * 16'd205;
      d_q    = (d_abs >= 16'd203) ? 6'd40 : d_prod[15:10];
      corr.fore = d_err[16] ? $signed({1'b0, d_q}) : -$signed({1'b0, d_q});
   end

endmodule

`default_nettype wire

/* hw/rtl/timed_trim_and_thrust_sequencer_unit.sv */
// Top level of the timed trim and thrust sequencer: input register, phase logic,
// run state and result register. Depends on tts_pkg, tts_csr and tts_trim.
//
// Use: the req_ channel carries start and adjust items; every item yields exactly
// one result item on the rsp_ channel, in order. A start item records its time,
// clears the one-shot flags and commands forward throttle. An adjust item picks
// the phase from the elapsed time against the trim, forward and reverse end
// points and returns servo and motor commands for that phase.
// Configuration registers are written through csr_; the user must write them only while
// the block is idle, which the block itself does not enforce. An accepted item passes
// through the input register, then the phase logic, into the result register.
// Throughput: one item per cycle while the receiver takes results, set by the single
// pass of logic between the two registers, which also updates the run state so the next
// item sees it.
// Reset clears all configuration registers, the start time, both one-shot flags
// and the valid flags of both registers. When the receiver stalls, the result
// register holds, the input register fills, and req_tready then falls; one item
// is held in each register.
`timescale 1ns / 1ps
`default_nettype none

module timed_trim_and_thrust_sequencer_unit
   import tts_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   // Input channel.
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [79:0]                 req_tdata,  // now_ms, heading_cdeg, pitch_cdeg, depth_mm
   input  wire [0:0]                  req_tuser,  // operation
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // servo_write, fore_dive_position, aft_dive_position, rudder_position,
   // motor_write, zero_pulse_first, motor_throttle, phase, run_complete
   output logic [55:0]                rsp_tdata,
   // Configuration port.
   input  wire                        csr_wr_en,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]   csr_wr_data
);

   tts_cfg_type  cfg;
   tts_corr_type corr;

   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic [31:0]        s1_now_ff;
   logic [15:0]        s1_heading_ff;
   logic signed [14:0] s1_pitch_ff;
   logic [15:0]        s1_depth_ff;

   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic [55:0] rsp_data_in;

   logic [31:0] start_time_ff, start_time_in;
   logic        servo_done_ff, servo_done_in;
   logic        zero_done_ff, zero_done_in;

   logic        out_load;
   logic [31:0] elapsed;
   logic [7:0]  fore0, aft0, rud0;

   logic               sw, mw, zp, done;
   logic signed [9:0]  fore, aft, rud;
   logic [15:0]        thr;
   logic [1:0]         ph;

   tts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tts_trim u_trim (
      .cfg          (cfg),
      .heading_cdeg (s1_heading_ff),
      .pitch_cdeg   (s1_pitch_ff),
      .depth_mm     (s1_depth_ff),
      .corr         (corr)
   );

   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;

   assign fore0   = cfg.servo_zero[7:0];
   assign aft0    = cfg.servo_zero[15:8];
   assign rud0    = cfg.servo_zero[23:16];
   assign elapsed = s1_now_ff - start_time_ff;

   always_comb begin
      sw   = 1'b0;
      mw   = 1'b0;
      zp   = 1'b0;
      done = 1'b0;
      fore = '0;
      aft  = '0;
      rud  = '0;
      thr  = '0;
      ph   = PHASE_TRIM;
      start_time_in = start_time_ff;
      servo_done_in = servo_done_ff;
      zero_done_in  = zero_done_ff;

      if (s1_op_ff == OP_START) begin
         start_time_in = s1_now_ff;
         servo_done_in = 1'b0;
         zero_done_in  = 1'b0;
         mw  = 1'b1;
         thr = cfg.throttle_pair[15:0];
      end else if (elapsed <= cfg.trim_end) begin
         sw   = 1'b1;
         fore = $signed({2'b00, fore0}) + {{3{corr.fore[6]}}, corr.fore};
         aft  = $signed({2'b00, aft0}) + {{3{corr.aft[6]}}, corr.aft};
         rud  = $signed({2'b00, rud0}) + {{4{corr.rudder[5]}}, corr.rudder};
         ph   = PHASE_TRIM;
      end else if (elapsed <= cfg.forward_end) begin
         // Servos go back to neutral only on the first forward item of a run.
         if (!servo_done_ff) begin
            sw   = 1'b1;
            fore = $signed({2'b00, fore0});
            aft  = $signed({2'b00, aft0});
            rud  = $signed({2'b00, rud0});
            servo_done_in = 1'b1;
         end
         ph = PHASE_FORWARD;
      end else if (elapsed <= cfg.reverse_end) begin
         mw = 1'b1;
         if (!zero_done_ff) begin
            zp = 1'b1;
            zero_done_in = 1'b1;
         end
         thr = cfg.throttle_pair[31:16];
         ph  = PHASE_REVERSE;
      end else begin
         mw   = 1'b1;
         ph   = PHASE_COMPLETE;
         done = 1'b1;
      end

      rsp_data_in = {4'd0, done, ph, thr, zp, mw, rud, aft, fore, sw};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff      <= req_tuser[0];
         s1_now_ff     <= req_tdata[31:0];
         s1_heading_ff <= req_tdata[47:32];
         s1_pitch_ff   <= $signed(req_tdata[62:48]);
         s1_depth_ff   <= req_tdata[78:63];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         start_time_ff <= '0;
         servo_done_ff <= 1'b0;
         zero_done_ff  <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff  <= 1'b1;
         start_time_ff <= start_time_in;
         servo_done_ff <= servo_done_in;
         zero_done_ff  <= zero_done_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* sim/timed_trim_and_thrust_sequencer_unit_tb.sv */
// Self-checking testbench for the timed trim and thrust sequencer: directed phase,
// rounding and wrap cases, then randomised runs under several register settings.
// Depends on tts_pkg and the timed_trim_and_thrust_sequencer_unit RTL.
`timescale 1ns / 1ps

module timed_trim_and_thrust_sequencer_unit_tb;
   import tts_pkg::*;

   // Result item as it sits in rsp_tdata, servo_write in bit 0.
   typedef struct packed {
      logic               run_complete;
      logic [1:0]         phase;
      logic signed [15:0] motor_throttle;
      logic               zero_pulse_first;
      logic               motor_write;
      logic signed [9:0]  rudder_position;
      logic signed [9:0]  aft_dive_position;
      logic signed [9:0]  fore_dive_position;
      logic               servo_write;
   } seq_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // now_ms, heading_cdeg, pitch_cdeg, depth_mm
   logic [0:0]  req_tuser = '0;  // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // servo_write, fore_dive_position, aft_dive_position, rudder_position,
   // motor_write, zero_pulse_first, motor_throttle, phase, run_complete
   logic [55:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data = '0;

   // Mirror of the block's registers and run state.
   tts_cfg_type mirror_cfg = '0;
   logic [31:0] run_start_ms = '0;
   logic        neutral_done = 1'b0;
   logic        zero_done = 1'b0;

   seq_result_type expected_results[$];
   int          mismatches = 0;
   logic        steady_flow = 1'b0;

   timed_trim_and_thrust_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int round_half_away(int n, int d);
      int a;
      int q;
      a = (n < 0) ? -n : n;
      q = (2 * a + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function automatic int clamp_mag(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Works out the result of one accepted item and advances the mirrored run state.
   function automatic seq_result_type predict_sequencer(logic op, logic [31:0] now,
                                                        logic [15:0] hdg,
                                                        logic signed [14:0] pit,
                                                        logic [15:0] dep);
      seq_result_type res;
      logic [31:0] elapsed;
      int dir, sp_head, sp_pitch, meas_pitch, r, p, d, fore0, aft0, rud0, pos;
      res = '0;
      fore0 = mirror_cfg.servo_zero[7:0];
      aft0 = mirror_cfg.servo_zero[15:8];
      rud0 = mirror_cfg.servo_zero[23:16];
      if (op == OP_START) begin
         run_start_ms = now;
         neutral_done = 1'b0;
         zero_done = 1'b0;
         res.motor_write = 1'b1;
         res.motor_throttle = mirror_cfg.throttle_pair[15:0];
         res.phase = PHASE_TRIM;
      end else begin
         elapsed = now - run_start_ms;
         if (elapsed <= mirror_cfg.trim_end) begin
            dir = hdg;
            if (dir > 18000) dir = dir - 36000;
            sp_head = mirror_cfg.heading_sp;
            sp_pitch = mirror_cfg.pitch_sp;
            meas_pitch = pit;
            r = clamp_mag(-round_half_away(sp_head - dir, 20), 30);
            p = clamp_mag(round_half_away(sp_pitch - meas_pitch, 50), 40);
            d = clamp_mag(-round_half_away(int'(mirror_cfg.depth_sp) - int'(dep), 5), 40);
            res.servo_write = 1'b1;
            pos = rud0 + r;
            res.rudder_position = pos[9:0];
            pos = aft0 + p;
            res.aft_dive_position = pos[9:0];
            pos = fore0 + d;
            res.fore_dive_position = pos[9:0];
            res.phase = PHASE_TRIM;
         end else if (elapsed <= mirror_cfg.forward_end) begin
            if (!neutral_done) begin
               res.servo_write = 1'b1;
               res.fore_dive_position = 10'(fore0);
               res.aft_dive_position = 10'(aft0);
               res.rudder_position = 10'(rud0);
               neutral_done = 1'b1;
            end
            res.phase = PHASE_FORWARD;
         end else if (elapsed <= mirror_cfg.reverse_end) begin
            res.motor_write = 1'b1;
            if (!zero_done) begin
               res.zero_pulse_first = 1'b1;
               zero_done = 1'b1;
            end
            res.motor_throttle = mirror_cfg.throttle_pair[31:16];
            res.phase = PHASE_REVERSE;
         end else begin
            res.motor_write = 1'b1;
            res.phase = PHASE_COMPLETE;
            res.run_complete = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         mismatches++;
      end
   endfunction

   // Sends one item after a random gap and records what it should produce.
   task automatic send_item(logic op, logic [31:0] now, logic [15:0] hdg,
                            logic signed [14:0] pit, logic [15:0] dep);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {1'b0, dep, pit, hdg, now};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_sequencer(op, now, hdg, pit, dep));
   endtask

   // Drops req_tvalid and lets every outstanding item come back, then idles before returning.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wr_data = data;
      case (index)
         REG_DEPTH_SP:    mirror_cfg.depth_sp = data[15:0];
         REG_PITCH_SP:    mirror_cfg.pitch_sp = data[14:0];
         REG_HEADING_SP:  mirror_cfg.heading_sp = data[15:0];
         REG_THROTTLE:    mirror_cfg.throttle_pair = data;
         REG_SERVO_ZERO:  mirror_cfg.servo_zero = data[23:0];
         REG_TRIM_END:    mirror_cfg.trim_end = data;
         REG_FORWARD_END: mirror_cfg.forward_end = data;
         REG_REVERSE_END: mirror_cfg.reverse_end = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic write_all_regs(logic [31:0] depth_sp, logic [31:0] pitch_sp,
                                 logic [31:0] heading_sp, logic [31:0] throttle,
                                 logic [31:0] zero_pos, logic [31:0] trim_end,
                                 logic [31:0] forward_end, logic [31:0] reverse_end);
      wait_idle();
      write_reg(REG_DEPTH_SP, depth_sp);
      write_reg(REG_PITCH_SP, pitch_sp & 32'h7FFF);
      write_reg(REG_HEADING_SP, heading_sp & 32'hFFFF);
      write_reg(REG_THROTTLE, throttle);
      write_reg(REG_SERVO_ZERO, zero_pos);
      write_reg(REG_TRIM_END, trim_end);
      write_reg(REG_FORWARD_END, forward_end);
      write_reg(REG_REVERSE_END, reverse_end);
   endtask

   // Adjust items straight after reset run against a start time of zero.
   task automatic test_unstarted_adjust();
      send_item(OP_ADJUST, 32'd0, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd7, 16'd30000, -15'sd1, 16'd65535);
   endtask

   task automatic test_extreme_corrections();
      write_all_regs(32'd65535, 32'd9000, -32'sd18000, 32'h8000_7FFF, 32'hFF_FFFF,
                     32'd1000, 32'd2000, 32'd3000);
      send_item(OP_START, 32'd0, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd0, 16'd0, -15'sd9000, 16'd0);
      send_item(OP_ADJUST, 32'd1000, 16'd35999, 15'sd9000, 16'd65535);
      send_item(OP_ADJUST, 32'd500, 16'hFFFF, 15'h4000, 16'd12345);
      send_item(OP_ADJUST, 32'd20, 16'd18000, 15'h3FFF, 16'd40000);
      send_item(OP_ADJUST, 32'd21, 16'd18001, 15'sd0, 16'd65000);
      // Exact halves must round away from zero in both directions.
      write_all_regs(32'd100, 32'd0, 32'd0, 32'h7FFF_8000, 32'd0,
                     32'd1000, 32'd2000, 32'd3000);
      send_item(OP_START, 32'd0, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd1, 16'd10, 15'sd25, 16'd97);
      send_item(OP_ADJUST, 32'd2, 16'd35990, -15'sd25, 16'd103);
   endtask

   // Walks one run through every phase across a wrap of the millisecond clock.
   task automatic test_phase_walk();
      logic [31:0] t0;
      write_all_regs(32'd0, -32'sd9000, 32'd18000, 32'h1234_ABCD, 32'h80_7F_01,
                     32'd10, 32'd20, 32'd30);
      t0 = 32'hFFFF_FFF8;
      send_item(OP_START, t0, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, t0 + 32'd10, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd11, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd15, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd21, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd30, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd31, 16'd9000, 15'sd100, 16'd3);
      send_item(OP_ADJUST, t0 + 32'd1000, 16'd9000, 15'sd100, 16'd3);
      // A fresh start must re-arm both one-shot flags.
      send_item(OP_START, 32'd5000, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd5011, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd5021, 16'd0, 15'sd0, 16'd0);
   endtask

   // End points out of order: an empty phase is skipped.
   task automatic test_disordered_ends();
      write_all_regs(32'd500, 32'd0, 32'd0, 32'hFFFF_0001, 32'h10_20_30,
                     32'd20, 32'd5, 32'd40);
      send_item(OP_START, 32'd0, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd30, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd41, 16'd0, 15'sd0, 16'd0);
      write_all_regs(32'd500, 32'd0, 32'd0, 32'hFFFF_0001, 32'h10_20_30,
                     32'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_START, 32'd100, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd100, 16'd0, 15'sd0, 16'd0);
      send_item(OP_ADJUST, 32'd99, 16'd0, 15'sd0, 16'd0);
   endtask

   // Mostly well-formed runs with random measurements, some stray times and restarts.
   task automatic test_random_runs();
      int setting, sent, run_len, pick;
      logic [31:0] t, tr, fw, rv;
      logic [15:0] hdg, dep;
      logic signed [14:0] pit;
      for (setting = 0; setting < 10; setting++) begin
         steady_flow = (setting == 3) || (setting == 7);
         if ($urandom_range(0, 3) == 0) begin
            tr = $urandom_range(0, 60);
            fw = $urandom_range(0, 60);
            rv = $urandom_range(0, 60);
         end else begin
            tr = $urandom_range(0, 40);
            fw = tr + $urandom_range(0, 40);
            rv = fw + $urandom_range(0, 40);
         end
         if (setting == 0)
            write_all_regs(32'd65535, 32'd9000, 32'd18000, 32'hFFFF_FFFF, 32'hFF_FFFF,
                           tr, fw, rv);
         else if (setting == 1)
            write_all_regs(32'd0, -32'sd9000, -32'sd18000, 32'd0, 32'd0, tr, fw, rv);
         else
            write_all_regs($urandom_range(0, 65535), $urandom_range(0, 18000) - 9000,
                           $urandom_range(0, 36000) - 18000, $urandom,
                           $urandom & 32'hFF_FFFF, tr, fw, rv);
         sent = 0;
         while (sent < 185) begin
            t = $urandom;
            send_item(OP_START, t, 16'($urandom), 15'($urandom), 16'($urandom));
            sent++;
            run_len = $urandom_range(4, 30);
            repeat (run_len) begin
               pick = $urandom_range(0, 99);
               if ($urandom_range(0, 4) == 0) hdg = 16'($urandom);
               else hdg = 16'($urandom_range(0, 35999));
               if ($urandom_range(0, 4) == 0) pit = 15'($urandom);
               else pit = 15'(int'($urandom_range(0, 18000)) - 9000);
               if ($urandom_range(0, 4) < 3)
                  dep = 16'(int'(mirror_cfg.depth_sp) + int'($urandom_range(0, 600)) - 300);
               else
                  dep = 16'($urandom);
               if (pick < 88) begin
                  t = t + $urandom_range(0, 12);
                  send_item(OP_ADJUST, t, hdg, pit, dep);
               end else if (pick < 95) begin
                  send_item(OP_ADJUST, $urandom, hdg, pit, dep);
               end else begin
                  send_item(OP_START, t, hdg, pit, dep);
               end
               sent++;
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   // Result side: random stall before each item, then compare with the oldest prediction.
   initial begin : result_monitor
      int stall;
      seq_result_type seen, want;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen = rsp_tdata[51:0];
         if (expected_results.size() == 0) begin
            $error("result item arrived with no prediction waiting: 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("servo_write", 16'(want.servo_write), 16'(seen.servo_write));
            check_field("fore_dive_position", 16'(want.fore_dive_position),
                        16'(seen.fore_dive_position));
            check_field("aft_dive_position", 16'(want.aft_dive_position),
                        16'(seen.aft_dive_position));
            check_field("rudder_position", 16'(want.rudder_position),
                        16'(seen.rudder_position));
            check_field("motor_write", 16'(want.motor_write), 16'(seen.motor_write));
            check_field("zero_pulse_first", 16'(want.zero_pulse_first),
                        16'(seen.zero_pulse_first));
            check_field("motor_throttle", want.motor_throttle, seen.motor_throttle);
            check_field("phase", 16'(want.phase), 16'(seen.phase));
            check_field("run_complete", 16'(want.run_complete), 16'(seen.run_complete));
         end
      end
   end

   initial begin : run_watchdog
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : test_sequence
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_unstarted_adjust();
      test_extreme_corrections();
      test_phase_walk();
      test_disordered_ends();
      test_random_runs();
      wait_idle();
      repeat (6) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
